// ----- hdl/cfq_pkg.sv -----
// Shared types and constants for the circular FIFO queue
`timescale 1ns / 1ps

package cfq_pkg;

	localparam int CFQ_DEPTH = 8;
	localparam int CFQ_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2,
		OP_DUMP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_OK    = 2'd0,
		RS_FULL  = 2'd1,
		RS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	typedef struct packed {
		logic    enq;
		logic    deq;
		logic    dump_start;
		logic    dump_step;
		logic    res_valid;
		logic    res_data;
		logic    res_last;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic head_is_tail;
		logic ptr_is_tail;
	} stat_t;

endpackage

// ----- hdl/cfq_ctrl.sv -----
// Controller state machine for the circular FIFO queue
`timescale 1ns / 1ps

module cfq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cfq_pkg::op_t  op,
	input  cfq_pkg::stat_t stat,
	output logic          busy,
	output cfq_pkg::cmd_t cmd
);
	import cfq_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && op == OP_DUMP && !stat.empty && !stat.head_is_tail) begin
					state_next = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (stat.ptr_is_tail) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = RS_OK;
		busy = (state_q == ST_DUMP);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.res_valid = 1'b1;
					cmd.res_last = 1'b1;
					unique case (op)
						OP_ENQUEUE: begin
							if (stat.full) begin
								cmd.res_status = RS_FULL;
							end else begin
								cmd.enq = 1'b1;
							end
						end
						OP_DEQUEUE: begin
							if (stat.empty) begin
								cmd.res_status = RS_EMPTY;
							end else begin
								cmd.deq = 1'b1;
								cmd.res_data = 1'b1;
							end
						end
						OP_PEEK: begin
							if (stat.empty) begin
								cmd.res_status = RS_EMPTY;
							end else begin
								cmd.res_data = 1'b1;
							end
						end
						OP_DUMP: begin
							if (stat.empty) begin
								cmd.res_status = RS_EMPTY;
							end else begin
								cmd.dump_start = 1'b1;
								cmd.res_data = 1'b1;
								cmd.res_last = stat.head_is_tail;
							end
						end
						default: cmd.res_status = RS_OK;
					endcase
				end
			end
			ST_DUMP: begin
				cmd.dump_step = 1'b1;
				cmd.res_valid = 1'b1;
				cmd.res_data = 1'b1;
				cmd.res_last = stat.ptr_is_tail;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/cfq_datapath.sv -----
// Ring store, pointers and result registers for the circular FIFO queue
`timescale 1ns / 1ps

module cfq_datapath #(
	parameter int DEPTH = cfq_pkg::CFQ_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cfq_pkg::cmd_t                        cmd,
	input  logic signed [cfq_pkg::CFQ_DATA_W-1:0] push_value,
	output cfq_pkg::stat_t                       stat,
	output logic                                 strobe,
	output logic [1:0]                           status,
	output logic signed [cfq_pkg::CFQ_DATA_W-1:0] read_value,
	output logic                                 last
);
	import cfq_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic [CFQ_DATA_W-1:0] mem [DEPTH];
	logic [CFQ_DATA_W-1:0] rd_q;
	logic [IW-1:0]         head_q;
	logic [IW-1:0]         tail_q;
	logic [IW-1:0]         ptr_q;
	logic                  empty_q;
	logic                  strobe_q;
	logic                  data_q;
	logic                  last_q;
	status_t               status_q;
	logic [IW-1:0]         head_nx;
	logic [IW-1:0]         tail_nx;
	logic [IW-1:0]         ptr_nx;
	logic [IW-1:0]         wr_addr;
	logic [IW-1:0]         rd_addr;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		logic [IW-1:0] r;
		if (i == IW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	assign head_nx = wrap_inc(head_q);
	assign tail_nx = wrap_inc(tail_q);
	assign ptr_nx  = wrap_inc(ptr_q);
	assign wr_addr = empty_q ? '0 : tail_nx;
	assign rd_addr = cmd.dump_step ? ptr_q : head_q;

	assign stat.empty        = empty_q;
	assign stat.full         = !empty_q && (tail_nx == head_q);
	assign stat.head_is_tail = (head_q == tail_q);
	assign stat.ptr_is_tail  = (ptr_q == tail_q);

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			mem[wr_addr] <= push_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			ptr_q   <= '0;
			empty_q <= 1'b1;
		end else begin
			if (cmd.enq) begin
				tail_q  <= wr_addr;
				empty_q <= 1'b0;
				if (empty_q) begin
					head_q <= '0;
				end
			end else if (cmd.deq) begin
				if (head_q == tail_q) begin
					empty_q <= 1'b1;
					head_q  <= '0;
					tail_q  <= '0;
				end else begin
					head_q <= head_nx;
				end
			end
			if (cmd.dump_start) begin
				ptr_q <= head_nx;
			end else if (cmd.dump_step) begin
				ptr_q <= ptr_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q   <= cmd.res_data;
		last_q   <= cmd.res_last;
		status_q <= cmd.res_status;
	end

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign last       = last_q;
	assign read_value = data_q ? $signed(rd_q) : '0;

endmodule

// ----- hdl/circular_fifo_queue.sv -----
// Top level of the circular FIFO queue
//
// Queue of signed 32-bit values in a ring of DEPTH entries, all usable.
// A transaction is accepted at a rising edge where start is high and busy
// is low; operation selects enqueue, dequeue, peek or dump, and
// push_value is the value stored by an enqueue.
// Each result appears on status, read_value and last for exactly one
// cycle, marked by strobe; it is registered and shows in the cycle after
// the edge that caused it. Enqueue, dequeue and peek leave busy low, so
// one transaction may be accepted in every cycle while busy is low. A
// dump of N stored entries emits N results, one ring read per cycle
// through the single read port; busy stays high through the final ring
// read, so the next transaction may be accepted in the cycle that shows
// the last dumped result. last marks the final result of each transaction.
// The receiver cannot stall: every result is taken in the cycle it shows.
// Reset empties the queue and clears head and tail; the ring contents are
// not cleared and are never read before being written.
`timescale 1ns / 1ps

module circular_fifo_queue #(
	parameter int DEPTH = cfq_pkg::CFQ_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           operation,
	input  logic signed [cfq_pkg::CFQ_DATA_W-1:0] push_value,
	output logic                                 strobe,
	output logic [1:0]                           status,
	output logic signed [cfq_pkg::CFQ_DATA_W-1:0] read_value,
	output logic                                 last
);
	import cfq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op_t'(operation)),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	cfq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (push_value),
		.stat       (stat),
		.strobe     (strobe),
		.status     (status),
		.read_value (read_value),
		.last       (last)
	);

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("accepted transaction gave no result");

	a_dump_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("dump cycle gave no result");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result without dump in progress");

	a_refusal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != RS_OK) |-> (last && read_value == '0))
		else $error("refused result carries data or is not final");

endmodule
